FILE: rtl/core/grid_multi_source_shortest_path_top_assert.svh
// Assertion macros for the grid shortest path block
`ifndef GRID_MULTI_SOURCE_SHORTEST_PATH_TOP_ASSERT_SVH
`define GRID_MULTI_SOURCE_SHORTEST_PATH_TOP_ASSERT_SVH

// Check that a property holds at every clock edge outside reset
`define GMSSP_CHECK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds
`define GMSSP_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/core/gmssp_pkg.sv
// Types and constants shared by the grid shortest path block
package gmssp_pkg;

    localparam logic [3:0]  CODE_SOURCE  = 4'd0;
    localparam logic [3:0]  CODE_BLOCKED = 4'd10;
    localparam logic [15:0] DIST_INF     = 16'hFFFF;

    localparam int          CFG_IDX_W    = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

    typedef struct packed {
        logic [3:0] cell_code;
        logic       last_cell;
    } gmssp_in_t;

    typedef struct packed {
        logic [15:0] max_distance;
        logic        unreachable;
    } gmssp_out_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_SELF,
        ST_CHK,
        ST_NB_ISS,
        ST_NB_DAT,
        ST_WR,
        ST_FIN,
        ST_OUT
    } gmssp_state_t;

endpackage

FILE: rtl/core/gmssp_store.sv
// Cell code and distance memories, one shared read address, registered reads
module gmssp_store #(
    parameter int AW = 12
) (
    input  logic          clk,
    input  logic          cell_we,
    input  logic [AW-1:0] cell_waddr,
    input  logic [3:0]    cell_wdata,
    input  logic          dist_we,
    input  logic [AW-1:0] dist_waddr,
    input  logic [15:0]   dist_wdata,
    input  logic [AW-1:0] rd_addr,
    output logic [3:0]    cell_rd,
    output logic [15:0]   dist_rd
);
    localparam int DEPTH = 1 << AW;

    logic [3:0]  cell_mem [DEPTH];
    logic [15:0] dist_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cell_mem[cell_waddr] <= cell_wdata;
        end
        cell_rd <= cell_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        dist_rd <= dist_mem[rd_addr];
    end
endmodule

FILE: rtl/core/grid_multi_source_shortest_path_top.sv
// Top level of the grid multi-source shortest path block
//
//  channel | direction | handshake           | payload
//  in      | request   | in_valid / in_stall | in_data (cell code, last mark)
//  out     | result    | out_valid/out_stall | out_data (max distance, flag)
//  cfg     | write     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Cells load at one per cycle into the cell memory. After the last cell the
// block seeds distances, then repeats forward sweeps until one changes
// nothing. Source, blocked and unloaded cells are skipped after their cell
// read; a weighted cell reads itself and each in-grid neighbor through the
// single shared read address, then writes back an improved distance. A
// final scan finds the result. No clearing pass runs after reset; the stores
// hold nothing meaningful until a grid is loaded. in_stall stays high from
// the last cell until the result is taken.
module grid_multi_source_shortest_path_top #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  gmssp_pkg::gmssp_in_t            in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output gmssp_pkg::gmssp_out_t           out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gmssp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [6:0]                      cfg_data
);
    import gmssp_pkg::*;

    localparam int AW = $clog2(MAX_ROWS * MAX_COLS);
    localparam int KW = AW + 1;
    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int CW = $clog2(MAX_COLS + 1);

    gmssp_state_t state_reg, state_next;

    logic [6:0]    rows_cfg_reg, cols_cfg_reg;
    logic [KW-1:0] k_reg, k_next;
    logic [KW-1:0] kp_reg, kp_next;
    logic [RW-1:0] r_reg, r_next;
    logic [CW-1:0] c_reg, c_next;
    logic [KW-1:0] lp_reg, lp_next;
    logic [KW-1:0] cnt_reg, cnt_next;
    logic [1:0]    nb_reg, nb_next;
    logic [15:0]   best_reg, best_next;
    logic [3:0]    w_reg, w_next;
    logic          upd_reg, upd_next;
    logic          changed_reg, changed_next;
    logic          pend_reg, pend_next;
    logic [15:0]   max_reg, max_next;
    logic          unr_reg, unr_next;

    logic [RW-1:0] rows_eff;
    logic [CW-1:0] cols_eff;
    logic [KW-1:0] total;

    logic          cell_we, dist_we;
    logic [AW-1:0] cell_waddr, dist_waddr, rd_addr;
    logic [3:0]    cell_wdata, cell_rd;
    logic [15:0]   dist_wdata, dist_rd;

    logic          nb_ok;
    logic [KW-1:0] nb_addr;
    logic [16:0]   cand;
    logic [3:0]    code_in, fin_code;
    logic          adv;

    // Clamp geometry: zero acts as one, above the maximum acts as the maximum
    always_comb
    begin
        if (rows_cfg_reg == 7'd0)
            rows_eff = RW'(1);
        else if (int'(rows_cfg_reg) > MAX_ROWS)
            rows_eff = RW'(MAX_ROWS);
        else
            rows_eff = RW'(rows_cfg_reg);
        if (cols_cfg_reg == 7'd0)
            cols_eff = CW'(1);
        else if (int'(cols_cfg_reg) > MAX_COLS)
            cols_eff = CW'(MAX_COLS);
        else
            cols_eff = CW'(cols_cfg_reg);
    end

    assign total = KW'(rows_eff * cols_eff);

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= 7'd64;
            cols_cfg_reg <= 7'd64;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_ROWS) rows_cfg_reg <= cfg_data;
            if (cfg_index == REG_COLS) cols_cfg_reg <= cfg_data;
        end
    end

    // Neighbor in order up, left, down, right
    always_comb
    begin
        unique case (nb_reg)
            2'd0:
            begin
                nb_ok   = (r_reg != '0);
                nb_addr = k_reg - KW'(cols_eff);
            end
            2'd1:
            begin
                nb_ok   = (c_reg != '0);
                nb_addr = k_reg - KW'(1);
            end
            2'd2:
            begin
                nb_ok   = (KW'(r_reg) + KW'(1) < KW'(rows_eff));
                nb_addr = k_reg + KW'(cols_eff);
            end
            default:
            begin
                nb_ok   = (KW'(c_reg) + KW'(1) < KW'(cols_eff));
                nb_addr = k_reg + KW'(1);
            end
        endcase
    end

    assign code_in  = (in_data.cell_code > CODE_BLOCKED) ? CODE_BLOCKED : in_data.cell_code;
    assign cand     = {1'b0, dist_rd} + {13'd0, w_reg};
    assign fin_code = (kp_reg < cnt_reg) ? cell_rd : CODE_BLOCKED;

    assign in_stall  = (state_reg != ST_LOAD);
    assign out_valid = (state_reg == ST_OUT);
    assign out_data.max_distance = unr_reg ? 16'd0 : max_reg;
    assign out_data.unreachable  = unr_reg;

    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        kp_next      = kp_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        lp_next      = lp_reg;
        cnt_next     = cnt_reg;
        nb_next      = nb_reg;
        best_next    = best_reg;
        w_next       = w_reg;
        upd_next     = upd_reg;
        changed_next = changed_reg;
        pend_next    = 1'b0;
        max_next     = max_reg;
        unr_next     = unr_reg;
        cell_we      = 1'b0;
        cell_waddr   = lp_reg[AW-1:0];
        cell_wdata   = code_in;
        dist_we      = 1'b0;
        dist_waddr   = kp_reg[AW-1:0];
        dist_wdata   = DIST_INF;
        rd_addr      = k_reg[AW-1:0];
        adv          = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    // Store the cell while room remains in the grid
                    if (lp_reg < total)
                    begin
                        cell_we = 1'b1;
                        lp_next = lp_reg + KW'(1);
                    end
                    if (in_data.last_cell)
                    begin
                        cnt_next   = (lp_next < total) ? lp_next : total;
                        lp_next    = '0;
                        k_next     = '0;
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                // Seed sources at zero, all else unreached
                if (pend_reg)
                begin
                    dist_we    = 1'b1;
                    dist_wdata = (kp_reg < cnt_reg && cell_rd == CODE_SOURCE) ? 16'd0 : DIST_INF;
                end
                if (k_reg < total)
                begin
                    pend_next = 1'b1;
                    kp_next   = k_reg;
                    k_next    = k_reg + KW'(1);
                end
                else if (!pend_reg)
                begin
                    k_next       = '0;
                    r_next       = '0;
                    c_next       = '0;
                    changed_next = 1'b0;
                    state_next   = ST_SELF;
                end
            end
            ST_SELF:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (k_reg >= cnt_reg || cell_rd == CODE_SOURCE || cell_rd >= CODE_BLOCKED)
                begin
                    adv = 1'b1;
                end
                else
                begin
                    best_next  = dist_rd;
                    w_next     = cell_rd;
                    upd_next   = 1'b0;
                    nb_next    = 2'd0;
                    state_next = ST_NB_ISS;
                end
            end
            ST_NB_ISS:
            begin
                rd_addr = nb_addr[AW-1:0];
                if (nb_ok)
                    state_next = ST_NB_DAT;
                else if (nb_reg == 2'd3)
                    state_next = ST_WR;
                else
                    nb_next = nb_reg + 2'd1;
            end
            ST_NB_DAT:
            begin
                if (dist_rd != DIST_INF && cand < {1'b0, best_reg})
                begin
                    best_next = cand[15:0];
                    upd_next  = 1'b1;
                end
                if (nb_reg == 2'd3)
                    state_next = ST_WR;
                else
                begin
                    nb_next    = nb_reg + 2'd1;
                    state_next = ST_NB_ISS;
                end
            end
            ST_WR:
            begin
                if (upd_reg)
                begin
                    dist_we      = 1'b1;
                    dist_waddr   = k_reg[AW-1:0];
                    dist_wdata   = best_reg;
                    changed_next = 1'b1;
                end
                adv = 1'b1;
            end
            ST_FIN:
            begin
                if (pend_reg && fin_code < CODE_BLOCKED)
                begin
                    if (dist_rd == DIST_INF)
                        unr_next = 1'b1;
                    else if (dist_rd > max_reg)
                        max_next = dist_rd;
                end
                if (k_reg < total)
                begin
                    pend_next = 1'b1;
                    kp_next   = k_reg;
                    k_next    = k_reg + KW'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                    state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // Advance to the next cell; at the sweep end repeat or scan
        if (adv)
        begin
            k_next     = k_reg + KW'(1);
            state_next = ST_SELF;
            if (KW'(c_reg) + KW'(1) >= KW'(cols_eff))
            begin
                c_next = '0;
                if (KW'(r_reg) + KW'(1) >= KW'(rows_eff))
                begin
                    r_next = '0;
                    k_next = '0;
                    if (changed_next)
                    begin
                        changed_next = 1'b0;
                    end
                    else
                    begin
                        max_next   = '0;
                        unr_next   = 1'b0;
                        state_next = ST_FIN;
                    end
                end
                else
                begin
                    r_next = r_reg + RW'(1);
                end
            end
            else
            begin
                c_next = c_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            k_reg       <= '0;
            kp_reg      <= '0;
            r_reg       <= '0;
            c_reg       <= '0;
            lp_reg      <= '0;
            cnt_reg     <= '0;
            nb_reg      <= '0;
            best_reg    <= '0;
            w_reg       <= '0;
            upd_reg     <= 1'b0;
            changed_reg <= 1'b0;
            pend_reg    <= 1'b0;
            max_reg     <= '0;
            unr_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            kp_reg      <= kp_next;
            r_reg       <= r_next;
            c_reg       <= c_next;
            lp_reg      <= lp_next;
            cnt_reg     <= cnt_next;
            nb_reg      <= nb_next;
            best_reg    <= best_next;
            w_reg       <= w_next;
            upd_reg     <= upd_next;
            changed_reg <= changed_next;
            pend_reg    <= pend_next;
            max_reg     <= max_next;
            unr_reg     <= unr_next;
        end
    end

    gmssp_store #(
        .AW(AW)
    ) u_store (
        .clk       (clk),
        .cell_we   (cell_we),
        .cell_waddr(cell_waddr),
        .cell_wdata(cell_wdata),
        .dist_we   (dist_we),
        .dist_waddr(dist_waddr),
        .dist_wdata(dist_wdata),
        .rd_addr   (rd_addr),
        .cell_rd   (cell_rd),
        .dist_rd   (dist_rd)
    );

`include "grid_multi_source_shortest_path_top_assert.svh"

    `GMSSP_CHECK(a_unr_zero, out_valid && out_data.unreachable |-> out_data.max_distance == 16'd0, "unreachable result carries a distance")
    `GMSSP_NEVER(a_dist_wr_load, dist_we && state_reg == ST_LOAD, "distance write while loading")
    `GMSSP_CHECK(a_load_bound, state_reg == ST_LOAD |-> lp_reg <= KW'(MAX_ROWS * MAX_COLS), "load position past the store")
    `GMSSP_CHECK(a_out_from_fin, $rose(out_valid) |-> $past(state_reg) == ST_FIN, "result shown without a final scan")

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the grid multi-source shortest path block
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gmssp_pkg::*;

    localparam int GRID_ROWS_MAX = 64;
    localparam int GRID_COLS_MAX = 64;
    localparam int CELL_DEPTH    = GRID_ROWS_MAX * GRID_COLS_MAX;
    localparam int RANDOM_CELLS  = 1350;
    localparam int CYCLE_LIMIT   = 6000000;
    // window in which neither side idles, and length of the one long
    // receiver hold-off that backs the block up onto its input
    localparam int QUIET_START   = 20000;
    localparam int QUIET_END     = 26000;
    localparam int HOLD_LEN      = 400;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    gmssp_in_t            in_data;
    logic                 out_valid;
    logic                 out_stall;
    gmssp_out_t           out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [6:0]           cfg_data;

    grid_multi_source_shortest_path_top #(
        .MAX_ROWS(GRID_ROWS_MAX),
        .MAX_COLS(GRID_COLS_MAX)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // cells waiting to be offered, and grid answers waiting to come out
    gmssp_in_t  cell_queue[$];
    gmssp_out_t answer_queue[$];

    // predictor state: its own copy of the geometry and the cell store
    logic [6:0] rows_reg;
    logic [6:0] cols_reg;
    logic [3:0] grid_code[CELL_DEPTH];
    int         load_pos;

    int cycle_count;
    int error_count;
    int grids_checked;
    int cells_sent;
    int unreach_seen;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d answers pending",
                     cycle_count, answer_queue.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int clamp_dim(logic [6:0] raw, int max_dim);
        if (raw == 7'd0)
            return 1;
        if (int'(raw) > max_dim)
            return max_dim;
        return int'(raw);
    endfunction

    // Solve the loaded grid: relax every weighted cell from its four
    // neighbors until a full pass changes nothing, then take the largest
    // cost over open cells, or flag an open cell that no source reaches.
    function automatic gmssp_out_t solve_grid();
        int         rows;
        int         cols;
        int         total;
        int         count;
        int         cost[CELL_DEPTH];
        bit         reach[CELL_DEPTH];
        bit         changed;
        int         nb;
        int         cand;
        int         best;
        bit         lost;
        int         r;
        int         c;
        int         k;
        int         d;
        gmssp_out_t answer;
        rows  = clamp_dim(rows_reg, GRID_ROWS_MAX);
        cols  = clamp_dim(cols_reg, GRID_COLS_MAX);
        total = rows * cols;
        count = (load_pos < total) ? load_pos : total;
        // positions not loaded in this grid act as blocked
        for (k = count; k < total; k++)
            grid_code[k] = CODE_BLOCKED;
        for (k = 0; k < total; k++)
        begin
            reach[k] = (grid_code[k] == CODE_SOURCE);
            cost[k]  = 0;
        end
        do
        begin
            changed = 1'b0;
            for (r = 0; r < rows; r++)
                for (c = 0; c < cols; c++)
                begin
                    k = r * cols + c;
                    if (grid_code[k] == CODE_SOURCE || grid_code[k] >= CODE_BLOCKED)
                        continue;
                    for (d = 0; d < 4; d++)
                    begin
                        nb = -1;
                        case (d)
                            0: if (r > 0) nb = k - cols;
                            1: if (c > 0) nb = k - 1;
                            2: if (r + 1 < rows) nb = k + cols;
                            default: if (c + 1 < cols) nb = k + 1;
                        endcase
                        if (nb < 0 || !reach[nb])
                            continue;
                        cand = cost[nb] + int'(grid_code[k]);
                        if (cand > 16'hFFFF)
                            cand = 16'hFFFF;
                        if (!reach[k] || cand < cost[k])
                        begin
                            cost[k]  = cand;
                            reach[k] = 1'b1;
                            changed  = 1'b1;
                        end
                    end
                end
        end
        while (changed);
        best = 0;
        lost = 1'b0;
        for (k = 0; k < total; k++)
        begin
            if (grid_code[k] >= CODE_BLOCKED)
                continue;
            if (!reach[k])
                lost = 1'b1;
            else if (cost[k] > best)
                best = cost[k];
        end
        answer.max_distance = lost ? 16'd0 : 16'(best);
        answer.unreachable  = lost;
        return answer;
    endfunction

    // Fold one accepted cell into the predicted grid.
    function automatic void take_cell(gmssp_in_t item);
        int         total;
        logic [3:0] code;
        total = clamp_dim(rows_reg, GRID_ROWS_MAX) * clamp_dim(cols_reg, GRID_COLS_MAX);
        code  = (item.cell_code > CODE_BLOCKED) ? CODE_BLOCKED : item.cell_code;
        if (load_pos < total)
        begin
            grid_code[load_pos] = code;
            load_pos++;
        end
        if (item.last_cell)
        begin
            answer_queue.push_back(solve_grid());
            load_pos = 0;
        end
    endfunction

    // Cell driver: offer the head of the queue, hold it while stalled,
    // and drop it once the block takes it.
    always @(posedge clk or negedge rst_n)
    begin
        bit taken;
        bit quiet;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            taken = in_valid && !in_stall;
            quiet = cycle_count >= QUIET_START && cycle_count < QUIET_END;
            if (taken)
            begin
                take_cell(in_data);
                void'(cell_queue.pop_front());
                cells_sent++;
            end
            if (in_valid && !taken)
                in_valid <= 1'b1;
            else if (cell_queue.size() > 0 && (quiet || $urandom_range(99) >= 38))
            begin
                in_valid <= 1'b1;
                in_data  <= cell_queue[0];
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result receiver: stall at random, except for one long hold-off that
    // starts the first time a result is offered while a cell waits, so the
    // block backs up onto its input.
    always @(posedge clk or negedge rst_n)
    begin
        bit quiet;
        int hold_left;
        bit hold_done;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            quiet = cycle_count >= QUIET_START && cycle_count < QUIET_END;
            if (!hold_done && out_valid && in_valid)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !quiet && $urandom_range(99) < 38;
        end
    end

    // Result checker: compare each taken result with the oldest answer.
    always @(posedge clk)
    begin
        gmssp_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (answer_queue.size() == 0)
            begin
                $error("result with no grid answer pending: %p", out_data);
                error_count++;
            end
            else
            begin
                want = answer_queue.pop_front();
                grids_checked++;
                if (want.unreachable)
                    unreach_seen++;
                if (out_data.max_distance !== want.max_distance)
                begin
                    $error("max_distance expected %0d actual %0d",
                           want.max_distance, out_data.max_distance);
                    error_count++;
                end
                if (out_data.unreachable !== want.unreachable)
                begin
                    $error("unreachable expected %0b actual %0b",
                           want.unreachable, out_data.unreachable);
                    error_count++;
                end
            end
        end
    end

    task automatic push_cell(logic [3:0] code, bit last);
        gmssp_in_t item;
        item.cell_code = code;
        item.last_cell = last;
        cell_queue.push_back(item);
    endtask

    // Wait until every queued cell is taken and every answer has come out,
    // then give the block time to rearm.
    task automatic drain();
        while (cell_queue.size() > 0 || in_valid || answer_queue.size() > 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [6:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_ROWS)
            rows_reg = val;
        else
            cols_reg = val;
    endtask

    task automatic set_geometry(logic [6:0] rows, logic [6:0] cols);
        drain();
        write_reg(REG_ROWS, rows);
        write_reg(REG_COLS, cols);
    endtask

    // Random cell code: mostly weights, some sources, a few blocked and
    // out-of-range codes.
    function automatic logic [3:0] random_code();
        int roll;
        roll = $urandom_range(99);
        if (roll < 12)
            return CODE_SOURCE;
        if (roll < 22)
            return CODE_BLOCKED;
        if (roll < 26)
            return 4'($urandom_range(15, 11));
        return 4'($urandom_range(9, 1));
    endfunction

    initial
    begin
        int rows;
        int cols;
        int total;
        int count;
        int roll;
        int i;
        int g;
        cycle_count   = 0;
        error_count   = 0;
        grids_checked = 0;
        cells_sent    = 0;
        unreach_seen  = 0;
        load_pos      = 0;
        rows_reg      = 7'd64;
        cols_reg      = 7'd64;
        cfg_valid     = 1'b0;
        cfg_index     = REG_ROWS;
        cfg_data      = '0;
        rst_n         = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part.
        // Reset geometry is 64x64: end early after three cells, so the
        // rest of the big grid counts as blocked.
        push_cell(CODE_SOURCE, 0);
        push_cell(4'd9, 0);
        push_cell(4'd1, 1);
        // Register value zero acts as one: single open cell with no source.
        set_geometry(7'd0, 7'd0);
        push_cell(4'd9, 1);
        // Single source, then single blocked cell (no open cell at all).
        push_cell(CODE_SOURCE, 1);
        push_cell(CODE_BLOCKED, 1);
        // Out-of-range codes behave as blocked; extra cells are ignored.
        set_geometry(7'd1, 7'd3);
        push_cell(CODE_SOURCE, 0);
        push_cell(4'd15, 0);
        push_cell(4'd9, 0);
        push_cell(4'd5, 0);
        push_cell(4'd11, 1);
        // Geometry change in the middle of a grid.
        set_geometry(7'd2, 7'd2);
        push_cell(4'd9, 0);
        push_cell(CODE_SOURCE, 0);
        drain();
        write_reg(REG_COLS, 7'd3);
        push_cell(4'd8, 0);
        push_cell(4'd7, 0);
        push_cell(4'd6, 0);
        push_cell(4'd12, 1);
        // Oversized register values clamp to the maximum: one column of 64,
        // source at the bottom so the costs climb back up.
        set_geometry(7'd127, 7'd1);
        for (i = 0; i < 63; i++)
            push_cell(4'd9, 0);
        push_cell(CODE_SOURCE, 1);
        set_geometry(7'd1, 7'd100);
        push_cell(CODE_SOURCE, 0);
        push_cell(4'd14, 1);
        // Several grids queued back to back, so cells wait on a held result.
        set_geometry(7'd2, 7'd3);
        for (g = 0; g < 4; g++)
            for (i = 0; i < 6; i++)
                push_cell(random_code(), i == 5);

        // Random part: mostly small grids, complete loads with random
        // content, some early or overlong loads.
        while (cells_sent + cell_queue.size() < RANDOM_CELLS)
        begin
            roll = $urandom_range(99);
            if (roll < 3)
            begin
                rows = 64;
                cols = 64;
            end
            else if (roll < 6)
            begin
                rows = $urandom_range(1, 2) == 1 ? 1 : $urandom_range(9, 32);
                cols = rows == 1 ? $urandom_range(9, 40) : 1;
            end
            else
            begin
                rows = $urandom_range(1, 8);
                cols = $urandom_range(1, 8);
            end
            set_geometry(7'(rows), 7'(cols));
            total = rows * cols;
            roll  = $urandom_range(99);
            if (total > 100)
                count = $urandom_range(1, 12);
            else if (roll < 10)
                count = $urandom_range(1, total);
            else if (roll < 18)
                count = total + $urandom_range(1, 4);
            else
                count = total;
            for (i = 0; i < count; i++)
                push_cell(random_code(), i == count - 1);
        end

        drain();
        repeat (64) @(negedge clk);
        $display("checked %0d grid answers (%0d with unreachable cells) from %0d cells",
                 grids_checked, unreach_seen, cells_sent);
        $display("geometries from 1x1 to 64x64, with early, overlong and reshaped loads");
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
